/* rtl/flag_framed_packet_receiver_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the flag framed packet receiver
// ---------------------------------------------------------------------------
`ifndef FLAG_FRAMED_PACKET_RECEIVER_TOP_ASSERT_SVH
`define FLAG_FRAMED_PACKET_RECEIVER_TOP_ASSERT_SVH

// Checked only while out of reset
`define FFPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define FFPR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/ffpr_pkg.sv */
// ---------------------------------------------------------------------------
// ffpr_pkg
// Shared types and constants of the flag framed packet receiver.
// ---------------------------------------------------------------------------
package ffpr_pkg;

    // Payload store depth and derived widths
    localparam int PAYLOAD_BYTES = 5;
    localparam int FILL_W        = $clog2(PAYLOAD_BYTES + 1);
    localparam int STORE_W       = $clog2(PAYLOAD_BYTES);

    // APB map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_START_FLAG    = 2'd0,
        REG_END_FLAG      = 2'd1,
        REG_TIMEOUT_TICKS = 2'd2
    } t_reg_idx;

    // Reset values of the registers
    localparam logic [7:0]  START_FLAG_RST    = 8'd255;
    localparam logic [7:0]  END_FLAG_RST      = 8'd254;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

    // Item kinds on the input tuser
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_BYTE = 1'b1;

    typedef struct packed {
        logic [7:0]  start_flag;
        logic [7:0]  end_flag;
        logic [15:0] timeout_ticks;
    } t_cfg;

endpackage

/* rtl/ffpr_cfg.sv */
// ---------------------------------------------------------------------------
// ffpr_cfg
// APB register file holding the start flag, end flag and timeout.
// ---------------------------------------------------------------------------
module ffpr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ffpr_pkg::ADDR_W-1:0]    paddr,
    input  logic [ffpr_pkg::DATA_W-1:0]    pwdata,
    output logic [ffpr_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output ffpr_pkg::t_cfg                 o_cfg
);
    import ffpr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite & pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_flag    <= START_FLAG_RST;
            r_cfg.end_flag      <= END_FLAG_RST;
            r_cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_START_FLAG:    r_cfg.start_flag    <= pwdata[7:0];
                REG_END_FLAG:      r_cfg.end_flag      <= pwdata[7:0];
                REG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_START_FLAG:    prdata = {24'd0, r_cfg.start_flag};
            REG_END_FLAG:      prdata = {24'd0, r_cfg.end_flag};
            REG_TIMEOUT_TICKS: prdata = {16'd0, r_cfg.timeout_ticks};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/flag_framed_packet_receiver_top.sv */
// ---------------------------------------------------------------------------
// flag_framed_packet_receiver_top
// Deframes start/end flagged packets from a stream of bytes and ticks.
// ---------------------------------------------------------------------------
// An accepted input beat passes the input register, then the result register,
// to become its result beat. Throughput: one item per cycle unless the
// result side stalls; the deframer state updates in one pass.
// Reset (synchronous, active low) closes any packet, clears the fill index,
// elapsed and drop counters, and restores the register defaults.
module flag_framed_packet_receiver_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
    input  logic                           s_axis_tuser,  // [0] func
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] mode_flag, [15:8] sail_angle, [23:16] helm_angle, [39:24] drop_total
    output logic [39:0]                    m_axis_tdata,
    output logic                           m_axis_tuser,  // [0] packet_valid
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ffpr_pkg::ADDR_W-1:0]    paddr,
    input  logic [ffpr_pkg::DATA_W-1:0]    pwdata,
    output logic [ffpr_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import ffpr_pkg::*;

    t_cfg w_cfg;

    ffpr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Pipeline control
    logic r_in_valid, r_out_valid;
    logic r_in_func;
    logic [7:0] r_in_byte;
    logic w_adv;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_func <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    // Deframer state
    logic              r_open;
    logic [FILL_W-1:0] r_fill;
    logic [15:0]       r_elapsed;
    logic [15:0]       r_drops;
    logic [7:0]        r_store [PAYLOAD_BYTES];

    logic              n_open;
    logic [FILL_W-1:0] n_fill;
    logic [15:0]       n_elapsed;
    logic [15:0]       n_drops;
    logic              n_pkt;
    logic              n_wr;
    logic              w_timeout;
    logic              w_open_a;
    logic [FILL_W-1:0] w_fill_a;
    logic              w_is_byte;

    // Single pass update for one item
    always_comb begin
        w_is_byte = (r_in_func == FUNC_BYTE);
        n_elapsed = r_elapsed;
        if (!w_is_byte && r_open && r_elapsed != 16'hFFFF) begin
            n_elapsed = r_elapsed + 16'd1;
        end
        // timeout check comes after the tick count
        w_timeout = r_open && (n_elapsed > w_cfg.timeout_ticks);
        w_open_a  = r_open && !w_timeout;
        w_fill_a  = w_timeout ? '0 : r_fill;
        n_open    = w_open_a;
        n_fill    = w_fill_a;
        n_drops   = r_drops + {15'd0, w_timeout};
        n_pkt     = 1'b0;
        n_wr      = 1'b0;
        if (w_is_byte) begin
            if (r_in_byte == w_cfg.start_flag) begin
                n_open    = 1'b1;
                n_fill    = '0;
                n_elapsed = '0;
            end else if (w_open_a && r_in_byte == w_cfg.end_flag &&
                         w_fill_a == FILL_W'(PAYLOAD_BYTES)) begin
                n_open = 1'b0;
                n_fill = '0;
                n_pkt  = 1'b1;
            end else if (w_open_a) begin
                if (w_fill_a < FILL_W'(PAYLOAD_BYTES)) begin
                    n_wr   = 1'b1;
                    n_fill = w_fill_a + FILL_W'(1);
                end else begin
                    // overflow drops the packet
                    n_open  = 1'b0;
                    n_fill  = '0;
                    n_drops = r_drops + 16'd1;
                end
            end
        end
    end

    logic w_fire;
    assign w_fire = r_in_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_fill    <= '0;
            r_elapsed <= '0;
            r_drops   <= '0;
        end else if (w_fire) begin
            r_open    <= n_open;
            r_fill    <= n_fill;
            r_elapsed <= n_elapsed;
            r_drops   <= n_drops;
        end
    end

    // Payload store, no reset
    always_ff @(posedge i_clk) begin
        if (w_fire && n_wr) begin
            r_store[r_fill[STORE_W-1:0]] <= r_in_byte;
        end
    end

    // Result register
    logic        r_pkt;
    logic [23:0] r_bytes;
    logic [15:0] r_drop_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_pkt      <= n_pkt;
            r_bytes    <= n_pkt ? {r_store[2], r_store[1], r_store[0]} : 24'd0;
            r_drop_out <= n_drops;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_pkt;
    assign m_axis_tdata  = {r_drop_out, r_bytes};

endmodule

/* rtl/ffpr_checker.sv */
// ---------------------------------------------------------------------------
// ffpr_checker
// Port level checks of the flag framed packet receiver, bound to the top.
// ---------------------------------------------------------------------------
`include "flag_framed_packet_receiver_top_assert.svh"

module ffpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    // A stalled result beat holds
    `FFPR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

    // Payload bytes are zero unless a packet completed
    `FFPR_ASSERT(a_zero_payload, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:0] == 24'd0, "payload bytes set without packet")

    // Input backpressure only when the result side is stalled
    `FFPR_ASSERT(a_ready_stall, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled with free pipeline")

    // Reset empties the result register
    `FFPR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind flag_framed_packet_receiver_top ffpr_checker u_ffpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
